/* hw/rtl/crdi_pkg.sv */
// Package: shared constants, request types and CRC helper for the record dedup index.
package crdi_pkg;

    localparam int INDEX_DEPTH = 64;
    localparam int SLOT_W      = (INDEX_DEPTH > 1) ? $clog2(INDEX_DEPTH) : 1;
    localparam int CNT_W       = $clog2(INDEX_DEPTH + 1);
    localparam int ENT_W       = 7;
    localparam int LEN_W       = 16;
    localparam int FRESH_W     = 16;

    localparam logic [31:0]      CRC_INIT          = 32'hFFFF_FFFF;
    localparam logic [31:0]      CRC_POLY          = 32'hEDB8_8320;
    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = LEN_W'(4096);

    localparam logic [1:0] ACT_INDEX = 2'd0;
    localparam logic [1:0] ACT_CHECK = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    localparam logic [1:0] KIND_STORED   = 2'd0;
    localparam logic [1:0] KIND_REJECTED = 2'd1;
    localparam logic [1:0] KIND_CHECK    = 2'd2;
    localparam logic [1:0] KIND_CLEARED  = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] log_id;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic        empty_record;
    } t_in_req;

    typedef struct packed {
        logic [1:0]       kind;
        logic             dup_hit;
        logic [31:0]      record_crc;
        logic [ENT_W-1:0] index_entries;
        logic [FRESH_W-1:0] fresh_count;
    } t_out_req;

    typedef struct packed {
        logic take;
        logic search;
        logic load_out;
    } t_ctl_cmd;

    typedef struct packed {
        logic emit;
        logic need_search;
        logic srch_done;
    } t_ctl_sts;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* hw/rtl/crdi_ctrl.sv */
// Controller: request handshakes, search sequencing and output valid.
module crdi_ctrl
    import crdi_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_ctl_sts i_sts,
    output t_ctl_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_SEARCH = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   ready;
    logic   take;
    logic   finish;

    assign ready  = (r_state == S_IDLE) && (!r_out_valid || !i_out_stall);
    assign take   = i_in_valid && ready;
    assign finish = (r_state == S_SEARCH) && i_sts.srch_done;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (take && i_sts.need_search) n_state = S_SEARCH;
            end
            S_SEARCH: begin
                if (finish) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) n_out_valid = 1'b0;
        if ((take && i_sts.emit) || finish) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall     = !ready;
    assign o_out_valid    = r_out_valid;
    assign o_cmd.take     = take;
    assign o_cmd.search   = (r_state == S_SEARCH);
    assign o_cmd.load_out = (take && i_sts.emit) || finish;

endmodule

/* hw/rtl/crdi_dpath.sv */
// Datapath: CRC accumulator, index ring memory, search sweep and result register.
module crdi_dpath
    import crdi_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_in_req          i_req,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_wdata,
    input  t_ctl_cmd         i_cmd,
    output t_ctl_sts         o_sts,
    output t_out_req         o_req
);

    logic [63:0] mem [INDEX_DEPTH];
    logic [63:0] r_rd_data;

    logic [LEN_W-1:0]   r_max, n_max;
    logic [31:0]        r_crc, n_crc;
    logic [LEN_W-1:0]   r_len, n_len;
    logic               r_stop, n_stop;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [CNT_W-1:0]   r_filled, n_filled;
    logic [FRESH_W-1:0] r_fresh, n_fresh;
    logic [31:0]        r_key_log, n_key_log;
    logic [31:0]        r_key_crc, n_key_crc;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_pend, n_pend;
    logic               r_pend_last, n_pend_last;
    t_out_req           r_out;

    logic [31:0]        crc_upd;
    logic [31:0]        fin;
    logic [FRESH_W-1:0] fresh_inc;
    logic               ends;
    logic               wr_en;
    logic               emit;
    logic               need_search;
    logic               issue;
    logic               hit;
    t_out_req           item_out;

    assign crc_upd   = crc_byte(r_crc, i_req.data_byte);
    assign ends      = i_req.last_byte || i_req.empty_record;
    assign fresh_inc = (r_fresh == '1) ? r_fresh : r_fresh + 1'b1;
    assign issue     = i_cmd.search && (r_idx < r_filled);
    assign hit       = r_pend && (r_rd_data == {r_key_log, r_key_crc});

    always_comb begin
        n_crc       = r_crc;
        n_len       = r_len;
        n_stop      = r_stop;
        n_slot      = r_slot;
        n_filled    = r_filled;
        n_fresh     = r_fresh;
        n_key_log   = r_key_log;
        n_key_crc   = r_key_crc;
        fin         = ~crc_upd;
        wr_en       = 1'b0;
        emit        = 1'b0;
        need_search = 1'b0;
        item_out    = '0;
        item_out.index_entries = ENT_W'(r_filled);
        item_out.fresh_count   = r_fresh;
        unique case (i_req.action)
            ACT_CLEAR: begin
                n_crc    = CRC_INIT;
                n_len    = '0;
                n_stop   = 1'b0;
                n_slot   = '0;
                n_filled = '0;
                n_fresh  = '0;
                emit     = 1'b1;
                item_out.kind          = KIND_CLEARED;
                item_out.index_entries = '0;
                item_out.fresh_count   = '0;
            end
            ACT_INDEX: begin
                item_out.kind = KIND_REJECTED;
                if (r_stop) begin
                    emit = ends;
                end else if (i_req.empty_record) begin
                    n_stop = 1'b1;
                    n_crc  = CRC_INIT;
                    n_len  = '0;
                    emit   = 1'b1;
                end else if (r_len >= r_max) begin
                    n_stop = 1'b1;
                    n_crc  = CRC_INIT;
                    n_len  = '0;
                    emit   = i_req.last_byte;
                end else if (!i_req.last_byte) begin
                    n_crc = crc_upd;
                    n_len = r_len + 1'b1;
                end else begin
                    n_crc  = CRC_INIT;
                    n_len  = '0;
                    wr_en  = 1'b1;
                    n_slot = (r_slot == SLOT_W'(INDEX_DEPTH - 1)) ? '0 : r_slot + 1'b1;
                    if (r_filled != CNT_W'(INDEX_DEPTH)) n_filled = r_filled + 1'b1;
                    emit   = 1'b1;
                    item_out.kind          = KIND_STORED;
                    item_out.record_crc    = fin;
                    item_out.index_entries = ENT_W'(n_filled);
                end
            end
            ACT_CHECK: begin
                if (i_req.empty_record) fin = '0;
                if (!ends) begin
                    n_crc = crc_upd;
                    if (r_len != '1) n_len = r_len + 1'b1;
                end else begin
                    n_crc     = CRC_INIT;
                    n_len     = '0;
                    n_key_log = i_req.log_id;
                    n_key_crc = fin;
                    if (r_filled == '0) begin
                        n_fresh = fresh_inc;
                        emit    = 1'b1;
                        item_out.kind        = KIND_CHECK;
                        item_out.record_crc  = fin;
                        item_out.fresh_count = fresh_inc;
                    end else begin
                        need_search = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_pend_last = 1'b0;
        if (i_cmd.take) begin
            n_idx = '0;
        end else if (issue) begin
            n_idx       = r_idx + 1'b1;
            n_pend      = 1'b1;
            n_pend_last = (r_idx == r_filled - 1'b1);
        end
    end

    always_comb begin
        n_max = r_max;
        if (i_cfg_we) n_max = i_cfg_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max       <= MAX_PAYLOAD_RESET;
            r_crc       <= CRC_INIT;
            r_len       <= '0;
            r_stop      <= 1'b0;
            r_slot      <= '0;
            r_filled    <= '0;
            r_fresh     <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
        end else begin
            r_max       <= n_max;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_pend_last <= n_pend_last;
            if (i_cmd.take) begin
                r_crc    <= n_crc;
                r_len    <= n_len;
                r_stop   <= n_stop;
                r_slot   <= n_slot;
                r_filled <= n_filled;
                r_fresh  <= n_fresh;
            end else if (i_cmd.search && o_sts.srch_done && !hit) begin
                r_fresh  <= fresh_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_key_log <= n_key_log;
            r_key_crc <= n_key_crc;
        end
        if (i_cmd.load_out) begin
            if (i_cmd.search) begin
                r_out.kind          <= KIND_CHECK;
                r_out.dup_hit       <= hit;
                r_out.record_crc    <= r_key_crc;
                r_out.index_entries <= ENT_W'(r_filled);
                r_out.fresh_count   <= hit ? r_fresh : fresh_inc;
            end else begin
                r_out <= item_out;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && wr_en) mem[r_slot] <= {i_req.log_id, fin};
        r_rd_data <= mem[r_idx[SLOT_W-1:0]];
    end

    assign o_sts.emit        = emit;
    assign o_sts.need_search = need_search;
    assign o_sts.srch_done   = r_pend && (hit || r_pend_last);
    assign o_req             = r_out;

endmodule

/* hw/rtl/crc_record_dedup_index_core.sv */
// Top level: record CRC-32 dedup index core, controller plus datapath.
// One payload byte per request; a byte that does not end a record, an index
// record end and a clear are each handled on acceptance, without a search. A
// check record end with a non-empty ring sweeps the 64-entry ring memory one
// entry per cycle through its single registered read port, stopping at the
// first match; the input stalls until the sweep is done. One output register
// holds a result; while that result is stalled the input stalls too, and a
// result leaving frees the register for the next request in the same cycle.
module crc_record_dedup_index_core
    import crdi_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_req          i_in_req,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_req         o_out_req,
    input  logic             i_cfg_we,
    input  logic [LEN_W-1:0] i_cfg_wdata
);

    t_ctl_cmd cmd;
    t_ctl_sts sts;

    crdi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    crdi_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_in_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_req       (o_out_req)
    );

endmodule
